### hw/rtl/multilevel_round_robin_scheduler_top_assert.svh
// Assertion macros for the multilevel round-robin scheduler.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef MULTILEVEL_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH
`define MULTILEVEL_ROUND_ROBIN_SCHEDULER_TOP_ASSERT_SVH

// Plain property, checked outside reset
`define MRRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define MRRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mrrs_pkg.sv
// Shared types and constants of the multilevel round-robin scheduler.
// No dependencies.
package mrrs_pkg;

  localparam int unsigned NumTasksDef      = 64;
  localparam int unsigned NumLevelsDef     = 8;
  localparam int unsigned SlotsPerLevelDef = 64;
  localparam int unsigned CmdQueueDepth    = 2;

  localparam int unsigned TaskIdW = 6;
  localparam int unsigned SliceW  = 8;
  localparam int unsigned LevelW  = 4;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_RUN    = 2'd1,
    OP_SLEEP  = 2'd2,
    OP_SWITCH = 2'd3
  } op_e;

  // Classified command as it sits in the queue
  typedef struct packed {
    op_e                op;
    logic [TaskIdW-1:0] tid;
    logic               tok;       // id names an existing slot
    logic               keep_lvl;  // keep the task's level
    logic [LevelW-1:0]  lvl;       // saturated target level
    logic [SliceW-1:0]  slice;
  } cmd_t;

  // Back end status seen by the top level
  typedef struct packed {
    logic busy;
    logic pop;
  } bk_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_ALLOC,
    ST_RUN_DEC,
    ST_SLP_CUR,
    ST_RM_RD,
    ST_RM_CMP,
    ST_CP_RD,
    ST_CP_WR,
    ST_RM_END,
    ST_ADD,
    ST_SW_CUR,
    ST_OUT,
    ST_OUT_T,
    ST_OUT_S
  } bk_state_e;

endpackage

### hw/rtl/mrrs_front.sv
// Front end: takes a command transfer, decodes and classifies it.
// Depends on mrrs_pkg.
module mrrs_front #(
  parameter int unsigned NUM_TASKS  = mrrs_pkg::NumTasksDef,
  parameter int unsigned NUM_LEVELS = mrrs_pkg::NumLevelsDef
) (
  input  logic                         start_i,
  input  logic                         q_full_i,
  input  logic [1:0]                   func_i,
  input  logic [mrrs_pkg::TaskIdW-1:0] task_id_i,
  input  logic signed [mrrs_pkg::LevelW-1:0] level_i,
  input  logic [mrrs_pkg::SliceW-1:0]  slice_i,
  output logic                         push_o,
  output mrrs_pkg::cmd_t               cmd_o
);
  import mrrs_pkg::*;

  logic [LevelW-1:0] lvl_raw;

  assign lvl_raw = level_i;
  assign push_o  = start_i && !q_full_i;

  // Decode: id range check and level saturation
  always_comb begin
    cmd_o.op       = op_e'(func_i);
    cmd_o.tid      = task_id_i;
    cmd_o.tok      = 32'(task_id_i) < NUM_TASKS;
    cmd_o.keep_lvl = lvl_raw[LevelW-1];
    cmd_o.slice    = slice_i;
    if (32'(lvl_raw) >= NUM_LEVELS) begin
      cmd_o.lvl = LevelW'(NUM_LEVELS - 1);
    end else begin
      cmd_o.lvl = lvl_raw;
    end
  end

endmodule

### hw/rtl/mrrs_fifo.sv
// Short command queue between front and back end.
// Depends on mrrs_pkg.
module mrrs_fifo #(
  parameter int unsigned DEPTH = mrrs_pkg::CmdQueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mrrs_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output mrrs_pkg::cmd_t rdata_o,
  output logic           empty_o,
  output logic           full_o
);
  import mrrs_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### hw/rtl/mrrs_back.sv
// Back end: sequencer that carries out scheduler commands on the slot
// tables and run queues, and registers one result per command. Uses mrrs_pkg.
module mrrs_back #(
  parameter int unsigned NUM_TASKS       = mrrs_pkg::NumTasksDef,
  parameter int unsigned NUM_LEVELS      = mrrs_pkg::NumLevelsDef,
  parameter int unsigned SLOTS_PER_LEVEL = mrrs_pkg::SlotsPerLevelDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_empty_i,
  input  mrrs_pkg::cmd_t               cmd_i,
  output mrrs_pkg::bk_stat_t           stat_o,
  output logic                         done_o,
  output logic [mrrs_pkg::TaskIdW-1:0] current_task_o,
  output logic [mrrs_pkg::SliceW-1:0]  current_slice_o,
  output logic                         jump_o,
  output logic [mrrs_pkg::TaskIdW-1:0] alloc_id_o,
  output logic                         status_o
);
  import mrrs_pkg::*;

  localparam int unsigned TW  = $clog2(NUM_TASKS);
  localparam int unsigned LW  = $clog2(NUM_LEVELS);
  localparam int unsigned SW  = $clog2(SLOTS_PER_LEVEL);
  localparam int unsigned CW  = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int unsigned AW  = LW + SW;
  localparam int unsigned IW  = (TW > TaskIdW) ? TW : TaskIdW;
  localparam int unsigned ATW = LW + SliceW;
  localparam logic [AW-1:0] InitAddr0 = '0;
  localparam logic [AW-1:0] InitAddr1 = {LW'(NUM_LEVELS - 1), SW'(0)};

  // Control state
  bk_state_e         state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [NUM_TASKS-1:0] free_q, free_d, run_q, run_d, awr_q, awr_d;
  logic              init0_q, init0_d, init1_q, init1_d;
  logic [CW-1:0]     cnt_q [NUM_LEVELS];
  logic [CW-1:0]     cnt_d [NUM_LEVELS];
  logic [SW-1:0]     cur_q [NUM_LEVELS];
  logic [SW-1:0]     cur_d [NUM_LEVELS];
  logic [LW-1:0]     act_q, act_d;
  logic              dirty_q, dirty_d;
  logic              done_q, done_d;

  // Working registers
  logic [TW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d;
  logic [LW-1:0]     rm_lvl_q, rm_lvl_d, tgt_q, tgt_d;
  logic              was_cur_q, was_cur_d, had_q, had_d, cvalid_q, cvalid_d;
  logic [TW-1:0]     before_q, before_d, ctask_q, ctask_d;
  logic              jump_q, jump_d, status_q, status_d;
  logic [TaskIdW-1:0] alloc_q, alloc_d;

  // Result registers
  logic [TaskIdW-1:0] o_task_q, o_task_d, o_alloc_q, o_alloc_d;
  logic [SliceW-1:0]  o_slice_q, o_slice_d;
  logic               o_jump_q, o_jump_d, o_status_q, o_status_d;

  // Memories
  logic [TW-1:0]     rq_mem [2**AW];
  logic [ATW-1:0]    at_mem [NUM_TASKS];
  logic              rq_re, rq_we, at_re, at_we;
  logic [AW-1:0]     rq_raddr, rq_waddr;
  logic [TW-1:0]     rq_wdata, rq_raw_q, rq_data;
  logic              rq_sub0_q, rq_sub1_q;
  logic [TW-1:0]     at_raddr, at_waddr, at_addr_q;
  logic [ATW-1:0]    at_wdata, at_raw_q, at_rst, at_data;
  logic              at_wflag_q;

  // Helpers
  logic [IW-1:0]     t_ext, idx_ext, ctask_ext;
  logic [TW-1:0]     tid;
  logic [LW-1:0]     at_lvl, new_lvl, sel_lvl;
  logic [SliceW-1:0] at_slice;
  logic [SW-1:0]     cur_clamp, rm_cur;
  logic [AW-1:0]     cur_addr;
  logic [CW-1:0]     rm_n, sw_nc, j_nx;
  logic              move, act_valid;

  assign t_ext     = IW'(cmd_q.tid);
  assign tid       = t_ext[TW-1:0];
  assign idx_ext   = IW'(idx_q);
  assign ctask_ext = IW'(ctask_q);

  // Run queue read data, with the two entries preset by reset
  assign rq_data = rq_sub0_q ? TW'(0) : (rq_sub1_q ? TW'(1) : rq_raw_q);

  // Slot attributes: unwritten slots read their reset value
  always_comb begin
    at_rst = '0;
    if (at_addr_q == TW'(0)) begin
      at_rst = {LW'(0), SliceW'(2)};
    end else if (at_addr_q == TW'(1)) begin
      at_rst = {LW'(NUM_LEVELS - 1), SliceW'(1)};
    end
  end
  assign at_data  = at_wflag_q ? at_raw_q : at_rst;
  assign at_lvl   = at_data[ATW-1:SliceW];
  assign at_slice = at_data[SliceW-1:0];

  // Current task address at the active level
  assign act_valid = (cnt_q[act_q] != '0);
  assign cur_clamp = (CW'(cur_q[act_q]) >= cnt_q[act_q]) ? '0 : cur_q[act_q];
  assign cur_addr  = {act_q, cur_clamp};

  // Lowest-numbered non-empty level, the last level if all are empty
  always_comb begin
    sel_lvl = LW'(NUM_LEVELS - 1);
    for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
      if (cnt_q[k] != '0) begin
        sel_lvl = LW'(k);
      end
    end
  end

  // Run decision
  assign new_lvl = cmd_q.keep_lvl ? at_lvl : cmd_q.lvl[LW-1:0];
  assign move    = (!run_q[tid] || (at_lvl != new_lvl)) &&
                   (cnt_q[new_lvl] < CW'(SLOTS_PER_LEVEL));

  // Removal bookkeeping: new count and cursor fix
  assign rm_n = cnt_q[rm_lvl_q] - 1'b1;
  always_comb begin
    rm_cur = cur_q[rm_lvl_q];
    if (i_q < CW'(rm_cur)) begin
      rm_cur = rm_cur - 1'b1;
    end
    if (CW'(rm_cur) >= rm_n) begin
      rm_cur = '0;
    end
  end
  assign j_nx  = j_q + 1'b1;
  assign sw_nc = CW'(cur_q[act_q]) + 1'b1;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    free_d    = free_q;
    run_d     = run_q;
    awr_d     = awr_q;
    init0_d   = init0_q;
    init1_d   = init1_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    act_d     = act_q;
    dirty_d   = dirty_q;
    idx_d     = idx_q;
    i_d       = i_q;
    j_d       = j_q;
    rm_lvl_d  = rm_lvl_q;
    tgt_d     = tgt_q;
    was_cur_d = was_cur_q;
    had_d     = had_q;
    before_d  = before_q;
    ctask_d   = ctask_q;
    cvalid_d  = cvalid_q;
    jump_d    = jump_q;
    status_d  = status_q;
    alloc_d   = alloc_q;
    o_task_d  = o_task_q;
    o_slice_d = o_slice_q;
    o_jump_d  = o_jump_q;
    o_alloc_d = o_alloc_q;
    o_status_d = o_status_q;
    done_d    = 1'b0;
    stat_o.busy = (state_q != ST_IDLE);
    stat_o.pop = 1'b0;
    rq_re     = 1'b0;
    rq_raddr  = cur_addr;
    rq_we     = 1'b0;
    rq_waddr  = '0;
    rq_wdata  = tid;
    at_re     = 1'b0;
    at_raddr  = tid;
    at_we     = 1'b0;
    at_waddr  = tid;
    at_wdata  = '0;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          stat_o.pop = 1'b1;
          cmd_d      = cmd_i;
          jump_d     = 1'b0;
          status_d   = 1'b0;
          alloc_d    = '0;
          was_cur_d  = 1'b0;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        case (cmd_q.op)
          OP_ALLOC: begin
            idx_d   = '0;
            state_d = ST_ALLOC;
          end
          OP_RUN: begin
            if (cmd_q.tok && !free_q[tid]) begin
              at_re   = 1'b1;
              state_d = ST_RUN_DEC;
            end else begin
              state_d = ST_OUT;
            end
          end
          OP_SLEEP: begin
            if (cmd_q.tok && run_q[tid]) begin
              rq_re   = 1'b1;
              at_re   = 1'b1;
              state_d = ST_SLP_CUR;
            end else begin
              state_d = ST_OUT;
            end
          end
          default: begin
            rq_re   = 1'b1;
            state_d = ST_SW_CUR;
          end
        endcase
      end
      // Scan for the lowest free slot
      ST_ALLOC: begin
        if (free_q[idx_q]) begin
          free_d[idx_q] = 1'b0;
          alloc_d       = idx_ext[TaskIdW-1:0];
          state_d       = ST_OUT;
        end else if (idx_q == TW'(NUM_TASKS - 1)) begin
          status_d = 1'b1;
          state_d  = ST_OUT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RUN_DEC: begin
        at_we       = 1'b1;
        at_wdata    = {move ? new_lvl : at_lvl,
                       (cmd_q.slice != '0) ? cmd_q.slice : at_slice};
        awr_d[tid]  = 1'b1;
        dirty_d     = 1'b1;
        if (move) begin
          tgt_d = new_lvl;
          if (run_q[tid]) begin
            rm_lvl_d = at_lvl;
            i_d      = '0;
            state_d  = ST_RM_RD;
          end else begin
            state_d = ST_ADD;
          end
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_SLP_CUR: begin
        was_cur_d = act_valid && (rq_data == tid);
        rm_lvl_d  = at_lvl;
        i_d       = '0;
        state_d   = ST_RM_RD;
      end
      // Linear search of the queue for the task
      ST_RM_RD: begin
        if (i_q >= cnt_q[rm_lvl_q]) begin
          run_d[tid] = 1'b0;
          state_d    = ST_RM_END;
        end else begin
          rq_re    = 1'b1;
          rq_raddr = {rm_lvl_q, i_q[SW-1:0]};
          state_d  = ST_RM_CMP;
        end
      end
      ST_RM_CMP: begin
        if (rq_data == tid) begin
          cnt_d[rm_lvl_q] = rm_n;
          cur_d[rm_lvl_q] = rm_cur;
          run_d[tid]      = 1'b0;
          j_d             = i_q;
          state_d         = ST_CP_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = ST_RM_RD;
        end
      end
      // Compaction: shift the tail down by one entry
      ST_CP_RD: begin
        if (j_q >= cnt_q[rm_lvl_q]) begin
          state_d = ST_RM_END;
        end else begin
          rq_re    = 1'b1;
          rq_raddr = {rm_lvl_q, j_nx[SW-1:0]};
          state_d  = ST_CP_WR;
        end
      end
      ST_CP_WR: begin
        rq_we    = 1'b1;
        rq_waddr = {rm_lvl_q, j_q[SW-1:0]};
        rq_wdata = rq_data;
        j_d      = j_nx;
        state_d  = ST_CP_RD;
      end
      ST_RM_END: begin
        if (cmd_q.op == OP_RUN) begin
          state_d = ST_ADD;
        end else begin
          if (was_cur_q) begin
            act_d   = sel_lvl;
            dirty_d = 1'b0;
          end
          state_d = ST_OUT;
        end
      end
      ST_ADD: begin
        rq_we        = 1'b1;
        rq_waddr     = {tgt_q, cnt_q[tgt_q][SW-1:0]};
        rq_wdata     = tid;
        cnt_d[tgt_q] = cnt_q[tgt_q] + 1'b1;
        run_d[tid]   = 1'b1;
        state_d      = ST_OUT;
      end
      // Timer tick: advance cursor, reselect if dirty
      ST_SW_CUR: begin
        had_d    = act_valid;
        before_d = rq_data;
        if (act_valid) begin
          cur_d[act_q] = (sw_nc >= cnt_q[act_q]) ? '0 : sw_nc[SW-1:0];
        end else begin
          cur_d[act_q] = '0;
        end
        if (dirty_q) begin
          act_d   = sel_lvl;
          dirty_d = 1'b0;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        rq_re   = 1'b1;
        state_d = ST_OUT_T;
      end
      ST_OUT_T: begin
        ctask_d  = rq_data;
        cvalid_d = act_valid;
        if (cmd_q.op == OP_SWITCH) begin
          jump_d = act_valid && (!had_q || (rq_data != before_q));
        end else if ((cmd_q.op == OP_SLEEP) && was_cur_q) begin
          jump_d = act_valid;
        end
        at_re    = 1'b1;
        at_raddr = rq_data;
        state_d  = ST_OUT_S;
      end
      ST_OUT_S: begin
        done_d     = 1'b1;
        o_task_d   = cvalid_q ? ctask_ext[TaskIdW-1:0] : '0;
        o_slice_d  = cvalid_q ? at_slice : '0;
        o_jump_d   = jump_q;
        o_alloc_d  = alloc_q;
        o_status_d = status_q;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Preset queue entries are gone once overwritten
    if (rq_we && (rq_waddr == InitAddr0)) begin
      init0_d = 1'b0;
    end
    if (rq_we && (rq_waddr == InitAddr1)) begin
      init1_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      free_q   <= {{(NUM_TASKS - 2){1'b1}}, 2'b00};
      run_q    <= {{(NUM_TASKS - 2){1'b0}}, 2'b11};
      awr_q    <= '0;
      init0_q  <= 1'b1;
      init1_q  <= 1'b1;
      for (int k = 0; k < NUM_LEVELS; k++) begin
        cnt_q[k] <= ((k == 0) || (k == NUM_LEVELS - 1)) ? CW'(1) : '0;
        cur_q[k] <= '0;
      end
      act_q    <= '0;
      dirty_q  <= 1'b1;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      free_q   <= free_d;
      run_q    <= run_d;
      awr_q    <= awr_d;
      init0_q  <= init0_d;
      init1_q  <= init1_d;
      cnt_q    <= cnt_d;
      cur_q    <= cur_d;
      act_q    <= act_d;
      dirty_q  <= dirty_d;
      done_q   <= done_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    i_q        <= i_d;
    j_q        <= j_d;
    rm_lvl_q   <= rm_lvl_d;
    tgt_q      <= tgt_d;
    was_cur_q  <= was_cur_d;
    had_q      <= had_d;
    before_q   <= before_d;
    ctask_q    <= ctask_d;
    cvalid_q   <= cvalid_d;
    jump_q     <= jump_d;
    status_q   <= status_d;
    alloc_q    <= alloc_d;
    o_task_q   <= o_task_d;
    o_slice_q  <= o_slice_d;
    o_jump_q   <= o_jump_d;
    o_alloc_q  <= o_alloc_d;
    o_status_q <= o_status_d;
  end

  // Run queue memory
  always_ff @(posedge clk_i) begin
    if (rq_we) begin
      rq_mem[rq_waddr] <= rq_wdata;
    end
    if (rq_re) begin
      rq_raw_q  <= rq_mem[rq_raddr];
      rq_sub0_q <= init0_q && (rq_raddr == InitAddr0);
      rq_sub1_q <= init1_q && (rq_raddr == InitAddr1);
    end
  end

  // Slot attribute memory: level and slice
  always_ff @(posedge clk_i) begin
    if (at_we) begin
      at_mem[at_waddr] <= at_wdata;
    end
    if (at_re) begin
      at_raw_q   <= at_mem[at_raddr];
      at_wflag_q <= awr_q[at_raddr];
      at_addr_q  <= at_raddr;
    end
  end

  assign done_o          = done_q;
  assign current_task_o  = o_task_q;
  assign current_slice_o = o_slice_q;
  assign jump_o          = o_jump_q;
  assign alloc_id_o      = o_alloc_q;
  assign status_o        = o_status_q;

endmodule

### hw/rtl/multilevel_round_robin_scheduler_top.sv
// Multilevel round-robin scheduler: commands are taken when start is high and
// busy is low; each produces one result, shown for exactly one cycle with
// done_o, which the receiver must take as it comes. A two-entry queue holds
// commands while the sequencer works. Alloc scans the slots in order for a
// free one; a run or sleep that moves a task is slowed by the one-port search
// and compaction of the run queue memory. No clearing pass is needed after
// reset.
// Depends on mrrs_pkg, mrrs_front, mrrs_fifo, mrrs_back and the assert header.
module multilevel_round_robin_scheduler_top #(
  parameter int unsigned NUM_TASKS       = mrrs_pkg::NumTasksDef,
  parameter int unsigned NUM_LEVELS      = mrrs_pkg::NumLevelsDef,
  parameter int unsigned SLOTS_PER_LEVEL = mrrs_pkg::SlotsPerLevelDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         func_i,
  input  logic [mrrs_pkg::TaskIdW-1:0]       task_id_i,
  input  logic signed [mrrs_pkg::LevelW-1:0] level_i,
  input  logic [mrrs_pkg::SliceW-1:0]        slice_i,
  output logic                               done_o,
  output logic [mrrs_pkg::TaskIdW-1:0]       current_task_o,
  output logic [mrrs_pkg::SliceW-1:0]        current_slice_o,
  output logic                               jump_o,
  output logic [mrrs_pkg::TaskIdW-1:0]       alloc_id_o,
  output logic                               status_o
);
  import mrrs_pkg::*;
  `include "multilevel_round_robin_scheduler_top_assert.svh"

  cmd_t     fe_cmd, q_cmd;
  logic     fe_push, q_empty, q_full;
  bk_stat_t bk_stat;

  assign busy = q_full;

  mrrs_front #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_front (
    .start_i   (start),
    .q_full_i  (q_full),
    .func_i    (func_i),
    .task_id_i (task_id_i),
    .level_i   (level_i),
    .slice_i   (slice_i),
    .push_o    (fe_push),
    .cmd_o     (fe_cmd)
  );

  mrrs_fifo #(
    .DEPTH (CmdQueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .wdata_i (fe_cmd),
    .pop_i   (bk_stat.pop),
    .rdata_o (q_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  mrrs_back #(
    .NUM_TASKS       (NUM_TASKS),
    .NUM_LEVELS      (NUM_LEVELS),
    .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .cmd_i           (q_cmd),
    .stat_o          (bk_stat),
    .done_o          (done_o),
    .current_task_o  (current_task_o),
    .current_slice_o (current_slice_o),
    .jump_o          (jump_o),
    .alloc_id_o      (alloc_id_o),
    .status_o        (status_o)
  );

  // Checks
  `MRRS_ASSERT(a_pop_nonempty, !bk_stat.pop || !q_empty, "pop from empty command queue")
  `MRRS_ASSERT_NEXT(a_push_lands, start && !busy, !q_empty, "accepted command lost")
  `MRRS_ASSERT(a_done_from_work, !done_o || $past(bk_stat.busy), "result without a command")

endmodule
